[hdl/pse_pkg.sv]
// shared types, constants and helper functions for the png stored-stream encoder
// no dependencies; used by every other file of the block but pse_ifs
package pse_pkg;

  localparam logic [14:0] MAX_DIM         = 15'd16384;
  localparam logic [16:0] STORE_BLOCK_MAX = 17'd65535;
  localparam logic [16:0] ADLER_MOD       = 17'd65521;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // last byte positions of the emitted runs
  localparam logic [5:0] HDR_LAST  = 6'd42;
  localparam logic [5:0] BHDR_LAST = 6'd4;
  localparam logic [5:0] TRL_LAST  = 6'd19;

  typedef enum logic [2:0] {
    OP_ERR,
    OP_HDR,
    OP_BHDR,
    OP_RAW,
    OP_TRL
  } op_t;

  typedef struct packed {
    logic       take;
    logic       div_start;
    logic       emit;
    op_t        op;
    logic [5:0] idx;
    logic       filt;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic can_emit;
    logic div_busy;
    logic dims_ok;
    logic in_data;
    logic row_start;
    logic fill_zero;
    logic last_pixel;
  } sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = (v >> 1) ^ (CRC_POLY & {32{v[0]}});
    end
    return v;
  endfunction

  // fixed bytes of the header run; variable positions read as zero here
  function automatic logic [7:0] hdr_fixed(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd0:  v = 8'h89;
      6'd1:  v = 8'h50;
      6'd2:  v = 8'h4E;
      6'd3:  v = 8'h47;
      6'd4:  v = 8'h0D;
      6'd5:  v = 8'h0A;
      6'd6:  v = 8'h1A;
      6'd7:  v = 8'h0A;
      6'd11: v = 8'h0D;
      6'd12: v = 8'h49;
      6'd13: v = 8'h48;
      6'd14: v = 8'h44;
      6'd15: v = 8'h52;
      6'd24: v = 8'h08;
      6'd25: v = 8'h06;
      6'd37: v = 8'h49;
      6'd38: v = 8'h44;
      6'd39: v = 8'h41;
      6'd40: v = 8'h54;
      6'd41: v = 8'h78;
      6'd42: v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] trl_fixed(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd12: v = 8'h49;
      6'd13: v = 8'h45;
      6'd14: v = 8'h4E;
      6'd15: v = 8'h44;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[hdl/pse_ifs.sv]
// valid/ready channel interfaces for pixel input and png byte output
// no dependencies
interface pse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

interface pse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       image_end;
  logic       dims_error;
  modport source (output valid, output out_byte, output run_last, output image_end,
                  output dims_error, input ready);
  modport sink (input valid, input out_byte, input run_last, input image_end,
                input dims_error, output ready);
endinterface

[hdl/pse_dp.sv]
// datapath: config registers, counters, adler-32, crc-32, idat length, output register
// depends on pse_pkg and pse_ifs
module pse_dp import pse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic [7:0]  pixel_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  pse_out_if.source   out_ch
);

  logic [14:0] width_r, height_r;
  logic        in_data_r;
  logic [14:0] row_r;
  logic [16:0] rowb_r;
  logic [15:0] fill_r;
  logic [30:0] rem_raw_r;
  logic [15:0] adl_lo_r, adl_hi_r;
  logic [31:0] crc_r;
  logic [7:0]  pixel_r;
  logic [30:0] raw_r;
  logic [15:0] blocks_r;
  logic        dbusy_r;
  logic        out_valid_r, run_last_r, image_end_r, dims_error_r;
  logic [7:0]  out_byte_r;

  logic [16:0] w4;
  logic [31:0] prod;
  logic [16:0] split_sum;
  logic        split_ge;
  logic [15:0] split_rem;
  logic [15:0] blocks;
  logic [31:0] idat_len;
  logic [31:0] ncrc;
  logic [15:0] blk_len;
  logic [15:0] blk_inv;
  logic        blk_final;
  logic [7:0]  raw_byte, byte_sel;
  logic        fed, clr;
  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_nxt, hi_nxt;
  logic        rearm, cfg_hit;

  assign w4   = {width_r, 2'b00};
  assign prod = 32'(w4 + 17'd1) * 32'(height_r);

  // ceiling of raw / 65535: with raw = a*65536 + b, raw = a*65535 + (a + b)
  assign split_sum = {2'b00, raw_r[30:16]} + {1'b0, raw_r[15:0]};
  assign split_ge  = (split_sum >= STORE_BLOCK_MAX);
  assign split_rem = split_ge ? 16'(split_sum - STORE_BLOCK_MAX) : split_sum[15:0];
  assign blocks    = {1'b0, raw_r[30:16]} + {15'd0, split_ge} + {15'd0, split_rem != 16'd0};

  assign idat_len = 32'(raw_r) + {14'd0, blocks_r, 2'b00} + {16'd0, blocks_r} + 32'd6;
  assign ncrc = ~crc_r;

  assign blk_final = 32'(rem_raw_r) <= 32'(STORE_BLOCK_MAX);
  assign blk_len   = blk_final ? rem_raw_r[15:0] : STORE_BLOCK_MAX[15:0];
  assign blk_inv   = ~blk_len;
  assign raw_byte  = cmd.filt ? 8'h00 : pixel_r;

  always_comb begin
    byte_sel = 8'h00;
    fed = 1'b0;
    clr = 1'b0;
    case (cmd.op)
      OP_HDR: begin
        byte_sel = hdr_fixed(cmd.idx);
        case (cmd.idx)
          6'd18: byte_sel = {1'b0, width_r[14:8]};
          6'd19: byte_sel = width_r[7:0];
          6'd22: byte_sel = {1'b0, height_r[14:8]};
          6'd23: byte_sel = height_r[7:0];
          6'd29: byte_sel = ncrc[31:24];
          6'd30: byte_sel = ncrc[23:16];
          6'd31: byte_sel = ncrc[15:8];
          6'd32: byte_sel = ncrc[7:0];
          6'd33: byte_sel = idat_len[31:24];
          6'd34: byte_sel = idat_len[23:16];
          6'd35: byte_sel = idat_len[15:8];
          6'd36: byte_sel = idat_len[7:0];
          default: ;
        endcase
        fed = (cmd.idx inside {[6'd12:6'd28], [6'd37:6'd42]});
        clr = (cmd.idx inside {6'd11, 6'd36});
      end
      OP_BHDR: begin
        case (cmd.idx)
          6'd0: byte_sel = {7'd0, blk_final};
          6'd1: byte_sel = blk_len[7:0];
          6'd2: byte_sel = blk_len[15:8];
          6'd3: byte_sel = blk_inv[7:0];
          default: byte_sel = blk_inv[15:8];
        endcase
        fed = 1'b1;
      end
      OP_RAW: begin
        byte_sel = raw_byte;
        fed = 1'b1;
      end
      OP_TRL: begin
        byte_sel = trl_fixed(cmd.idx);
        case (cmd.idx)
          6'd0:  byte_sel = adl_hi_r[15:8];
          6'd1:  byte_sel = adl_hi_r[7:0];
          6'd2:  byte_sel = adl_lo_r[15:8];
          6'd3:  byte_sel = adl_lo_r[7:0];
          6'd4, 6'd16: byte_sel = ncrc[31:24];
          6'd5, 6'd17: byte_sel = ncrc[23:16];
          6'd6, 6'd18: byte_sel = ncrc[15:8];
          6'd7, 6'd19: byte_sel = ncrc[7:0];
          default: ;
        endcase
        fed = (cmd.idx inside {[6'd0:6'd3], [6'd12:6'd15]});
        clr = (cmd.idx == 6'd11);
      end
      default: ;
    endcase
  end

  // adler-32 with single-subtract reduction
  always_comb begin
    lo_sum = {1'b0, adl_lo_r} + {9'd0, raw_byte};
    lo_nxt = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    hi_sum = {1'b0, adl_hi_r} + {1'b0, lo_nxt};
    hi_nxt = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
  end

  assign cfg_hit = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);
  assign rearm = cfg_hit || (cmd.emit && cmd.op == OP_TRL && cmd.idx == TRL_LAST);

  assign sts.can_emit   = !out_valid_r || out_ch.ready;
  assign sts.div_busy   = dbusy_r;
  assign sts.dims_ok    = (width_r != 15'd0) && (height_r != 15'd0) &&
                          (width_r <= MAX_DIM) && (height_r <= MAX_DIM);
  assign sts.in_data    = in_data_r;
  assign sts.row_start  = (rowb_r == 17'd0);
  assign sts.fill_zero  = (fill_r == 16'd0);
  assign sts.last_pixel = (rowb_r + 17'd1 == w4) && (row_r + 15'd1 == height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 15'd1;
      height_r    <= 15'd1;
      in_data_r   <= 1'b0;
      row_r       <= 15'd0;
      rowb_r      <= 17'd0;
      fill_r      <= 16'd0;
      rem_raw_r   <= 31'd0;
      adl_lo_r    <= 16'd1;
      adl_hi_r    <= 16'd0;
      crc_r       <= CRC_INIT;
      dbusy_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_WIDTH)  width_r  <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_HEIGHT) height_r <= cfg_wdata;

      // block count is registered in the cycle after the raw length
      dbusy_r <= cmd.div_start;

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.emit) begin
        if (fed) crc_r <= crc_byte(crc_r, byte_sel);
        if (clr) crc_r <= CRC_INIT;
        if (cmd.op == OP_HDR && cmd.idx == HDR_LAST) begin
          in_data_r <= 1'b1;
          rem_raw_r <= raw_r;
          row_r     <= 15'd0;
          rowb_r    <= 17'd0;
          fill_r    <= 16'd0;
          adl_lo_r  <= 16'd1;
          adl_hi_r  <= 16'd0;
        end
        if (cmd.op == OP_RAW) begin
          adl_lo_r <= lo_nxt;
          adl_hi_r <= hi_nxt;
          if (17'(fill_r) + 17'd1 >= STORE_BLOCK_MAX) fill_r <= 16'd0;
          else fill_r <= fill_r + 16'd1;
          if (rem_raw_r != 31'd0) rem_raw_r <= rem_raw_r - 31'd1;
          if (!cmd.filt) begin
            if (rowb_r + 17'd1 == w4) begin
              rowb_r <= 17'd0;
              row_r  <= row_r + 15'd1;
            end else begin
              rowb_r <= rowb_r + 17'd1;
            end
          end
        end
      end

      if (rearm) begin
        in_data_r <= 1'b0;
        row_r     <= 15'd0;
        rowb_r    <= 17'd0;
        fill_r    <= 16'd0;
        rem_raw_r <= 31'd0;
        adl_lo_r  <= 16'd1;
        adl_hi_r  <= 16'd0;
        crc_r     <= CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) pixel_r <= pixel_byte;
    if (cmd.div_start) raw_r <= prod[30:0];
    if (dbusy_r) blocks_r <= blocks;
    if (cmd.emit) begin
      out_byte_r   <= byte_sel;
      run_last_r   <= cmd.last;
      image_end_r  <= (cmd.op == OP_TRL) && (cmd.idx == TRL_LAST);
      dims_error_r <= (cmd.op == OP_ERR);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.image_end  = image_end_r;
  assign out_ch.dims_error = dims_error_r;

  a_adler_lo: assert property (@(posedge clk) disable iff (!rst_n)
    17'(adl_lo_r) < ADLER_MOD) else $error("adler low sum out of range");
  a_adler_hi: assert property (@(posedge clk) disable iff (!rst_n)
    17'(adl_hi_r) < ADLER_MOD) else $error("adler high sum out of range");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    17'(fill_r) < STORE_BLOCK_MAX) else $error("stored block overfilled");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dims_error_r) |-> (out_byte_r == 8'h00 && run_last_r))
    else $error("error beat carries data");

endmodule

[hdl/pse_ctrl.sv]
// controller: sequences header, block headers, raw bytes and trailer from the pixel beats, or an error beat
// depends on pse_pkg
module pse_ctrl import pse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_ERR, S_CALC, S_HDR, S_DEC, S_BHDR, S_RAW, S_TRL
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic       filt_r, filt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    filt_nxt  = filt_r;
    cmd       = '0;
    cmd.op    = OP_ERR;
    cmd.idx   = idx_r;
    cmd.filt  = filt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (!sts.dims_ok) begin
            state_nxt = S_ERR;
          end else if (!sts.in_data) begin
            cmd.div_start = 1'b1;
            state_nxt = S_CALC;
          end else begin
            filt_nxt  = sts.row_start;
            state_nxt = S_DEC;
          end
        end
      end
      S_ERR: begin
        if (sts.can_emit) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_ERR;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CALC: begin
        if (!sts.div_busy) begin
          idx_nxt   = 6'd0;
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        cmd.op = OP_HDR;
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (idx_r == HDR_LAST) begin
            filt_nxt  = 1'b1;
            state_nxt = S_DEC;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      S_DEC: begin
        // a stored block header goes ahead of the first raw byte of each block
        idx_nxt   = 6'd0;
        state_nxt = sts.fill_zero ? S_BHDR : S_RAW;
      end
      S_BHDR: begin
        cmd.op = OP_BHDR;
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (idx_r == BHDR_LAST) state_nxt = S_RAW;
          else idx_nxt = idx_r + 6'd1;
        end
      end
      S_RAW: begin
        cmd.op = OP_RAW;
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (filt_r) begin
            filt_nxt  = 1'b0;
            state_nxt = S_DEC;
          end else if (sts.last_pixel) begin
            idx_nxt   = 6'd0;
            state_nxt = S_TRL;
          end else begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_TRL: begin
        cmd.op = OP_TRL;
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (idx_r == TRL_LAST) begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 6'd0;
      filt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      filt_r  <= filt_nxt;
    end
  end

endmodule

[hdl/png_stored_stream_encoder.sv]
// one beat in flight at a time: a beat with valid dims passes S_DEC, then its bytes are
// registered at the output; an image's first beat also waits in S_CALC for the idat length
// throughput: one output byte per cycle within a run while the output is ready; a plain
// beat passes idle, decide and raw states, more at row, block and image boundaries
// reset: synchronous active-low rst_n; width and height read 1, image restarts at the header
module png_stored_stream_encoder import pse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata,
  pse_in_if.sink      in_ch,
  pse_out_if.source   out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic ready;

  assign in_ch.ready = ready;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pse_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pixel_byte (in_ch.pixel_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_ch     (out_ch)
  );

endmodule
